// ===== design/swtm_pkg.sv =====
// ----------------------------------------------------------------------------
// swtm_pkg: shared definitions for the sliding window trimmed mean
// Defaults, configuration register indexes and the structs that travel
// between the cell row, the divider and the top level.
// ----------------------------------------------------------------------------
package swtm_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int WLEN_BITS     = 7;
    localparam int TRIM_BITS     = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_COUNT    = 2'd1;

    localparam logic [WLEN_BITS-1:0] RESET_WINDOW_LENGTH = 7'd3;
    localparam logic [TRIM_BITS-1:0] RESET_TRIM_COUNT    = 5'd1;

    // broadcast to every cell
    typedef struct packed {
        logic clear;
        logic update;
        logic full;
    } cell_ctrl_t;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic occ;
        logic gt;
    } cell_link_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== design/swtm_ifs.sv =====
// ----------------------------------------------------------------------------
// swtm channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface swtm_sample_if #(
    parameter int SAMPLE_BITS = swtm_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swtm_result_if #(
    parameter int SAMPLE_BITS = swtm_pkg::DEF_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   valid_res;
    logic [SAMPLE_BITS-1:0] average;

    modport source (output valid, output valid_res, output average, input ready);
    modport sink   (input valid, input valid_res, input average, output ready);
endinterface

interface swtm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [swtm_pkg::CFG_IDX_BITS-1:0]  index;
    logic [swtm_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/sliding_window_trimmed_mean.sv =====
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean: alpha-trimmed mean over a sliding window
// A ring keeps arrival order; a row of sorted cells keeps rank order.
// Each beat of samples gives one beat of results.
//
//   channel   dir  handshake          payload
//   cfg       in   valid/ready        index, data
//   samples   in   valid/ready        sample
//   results   out  valid/ready        valid_res, average
//
// A sample whose result is valid passes the insert, sum, divider start,
// divide and done states: the partial sum ripples through every cell, then
// the divider makes one quotient bit per cycle. A sample whose result is not
// valid goes from the insert state straight to the done state.
// Reset empties the window and loads window_length 3 and trim_count 1.
// A held result blocks the next result, not the next sample.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean #(
    parameter int MAX_WINDOW  = swtm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swtm_pkg::DEF_SAMPLE_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    swtm_cfg_if.sink        cfg,
    swtm_sample_if.sink     samples,
    swtm_result_if.source   results
);

    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_DIV_GO = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [swtm_pkg::WLEN_BITS-1:0]   wlen_reg;
    logic [swtm_pkg::TRIM_BITS-1:0]   trim_reg;
    logic [PTR_BITS-1:0]              wp_reg, wp_next;
    logic [LEN_BITS-1:0]              fill_reg, fill_next;
    logic [PTR_BITS-1:0]              cnt_reg, cnt_next;
    logic                             full_reg;
    logic                             store_reg;
    logic                             mid_ok_reg, mid_ok_next;
    logic [SAMPLE_BITS-1:0]           sample_reg;
    logic [SAMPLE_BITS-1:0]           old_reg;
    logic [SAMPLE_BITS-1:0]           avg_reg;
    logic                             res_vld_reg, res_vld_next;
    logic                             res_flag_reg;
    logic [SAMPLE_BITS-1:0]           res_avg_reg;

    logic [SAMPLE_BITS-1:0]           ring_mem [MAX_WINDOW];

    logic                             cfg_wr;
    logic                             cfg_hit;
    logic                             in_acc;
    logic                             out_acc;
    logic                             res_load;
    logic [LEN_BITS-1:0]              eff_len;
    logic [swtm_pkg::TRIM_BITS:0]     two_trim;
    logic                             trim_ok;
    logic [LEN_BITS-1:0]              lo;
    logic [LEN_BITS-1:0]              hi;
    logic [LEN_BITS-1:0]              divisor;
    logic [LEN_BITS-1:0]              wp_inc;
    logic                             fills_now;

    swtm_pkg::cell_ctrl_t             ctrl;
    swtm_pkg::div_status_t            div_stat;
    logic [SUM_BITS-1:0]              quotient;

    logic [SAMPLE_BITS-1:0]           a_val_w [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]            occ_w;
    logic [SAMPLE_BITS-1:0]           c_val_w [MAX_WINDOW];
    swtm_pkg::cell_link_t             link_w  [MAX_WINDOW];
    logic [SUM_BITS-1:0]              psum_w  [MAX_WINDOW];

    assign cfg_wr  = cfg.valid && cfg.ready;
    assign in_acc  = samples.valid && samples.ready;
    assign out_acc = results.valid && results.ready;

    // writes to indexes outside the register map leave the window alone
    assign cfg_hit = cfg_wr && ((cfg.index == swtm_pkg::REG_WINDOW_LENGTH) ||
                                (cfg.index == swtm_pkg::REG_TRIM_COUNT));

    assign cfg.ready       = 1'b1;
    assign samples.ready   = (state_reg == ST_IDLE);
    assign results.valid   = res_vld_reg;
    assign results.valid_res = res_flag_reg;
    assign results.average = res_avg_reg;

    // the length saturates at the size of the cell row
    assign eff_len  = (32'(wlen_reg) > MAX_WINDOW) ? LEN_BITS'(MAX_WINDOW)
                                                   : LEN_BITS'(wlen_reg);
    assign two_trim = {trim_reg, 1'b0};
    assign trim_ok  = 32'(two_trim) < 32'(eff_len);
    assign lo       = LEN_BITS'(trim_reg);
    assign hi       = eff_len - LEN_BITS'(trim_reg);
    assign divisor  = eff_len - LEN_BITS'(two_trim);
    assign wp_inc   = LEN_BITS'(wp_reg) + LEN_BITS'(1);
    assign fills_now = full_reg || ((fill_reg + LEN_BITS'(1)) == eff_len);
    assign res_load = (state_reg == ST_DONE) && (!res_vld_reg || results.ready);

    assign ctrl = '{clear: cfg_hit,
                    update: (state_reg == ST_INSERT) && store_reg,
                    full: full_reg};

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        mid_ok_next = mid_ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (store_reg)
                begin
                    fill_next = full_reg ? fill_reg : fill_reg + LEN_BITS'(1);
                    wp_next   = (wp_inc >= eff_len) ? '0 : PTR_BITS'(wp_inc);
                end
                mid_ok_next = store_reg && fills_now && trim_ok;
                cnt_next    = '0;
                state_next  = (store_reg && fills_now && trim_ok) ? ST_SUM : ST_DONE;
            end
            ST_SUM:
            begin
                cnt_next = cnt_reg + PTR_BITS'(1);
                if (cnt_reg == PTR_BITS'(MAX_WINDOW - 1))
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a register write empties the window
        if (cfg_hit)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
    end

    assign res_vld_next = res_load || (res_vld_reg && !out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= swtm_pkg::RESET_WINDOW_LENGTH;
            trim_reg    <= swtm_pkg::RESET_TRIM_COUNT;
            wp_reg      <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            mid_ok_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            mid_ok_reg  <= mid_ok_next;
            res_vld_reg <= res_vld_next;
            if (cfg_wr)
            begin
                case (cfg.index)
                    swtm_pkg::REG_WINDOW_LENGTH:
                        wlen_reg <= cfg.data[swtm_pkg::WLEN_BITS-1:0];
                    swtm_pkg::REG_TRIM_COUNT:
                        trim_reg <= cfg.data[swtm_pkg::TRIM_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ring read returns the oldest sample before it is overwritten
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            old_reg          <= ring_mem[wp_reg];
            ring_mem[wp_reg] <= samples.sample;
            sample_reg       <= samples.sample;
            full_reg         <= (fill_reg == eff_len);
            store_reg        <= (eff_len != '0);
        end
        if (div_stat.done)
        begin
            avg_reg <= quotient[SAMPLE_BITS-1:0];
        end
        if (res_load)
        begin
            res_flag_reg <= mid_ok_reg;
            res_avg_reg  <= mid_ok_reg ? avg_reg : '0;
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] left_c_val;
        swtm_pkg::cell_link_t   left_link;
        logic [SAMPLE_BITS-1:0] right_val;
        logic                   right_occ;
        logic [SUM_BITS-1:0]    psum_in;

        if (i == 0)
        begin : g_first
            assign left_c_val = '0;
            assign left_link  = '{occ: 1'b0, gt: 1'b0};
            assign psum_in    = '0;
        end
        else
        begin : g_inner
            assign left_c_val = c_val_w[i-1];
            assign left_link  = link_w[i-1];
            assign psum_in    = psum_w[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign right_val = '0;
            assign right_occ = 1'b0;
        end
        else
        begin : g_body
            assign right_val = a_val_w[i+1];
            assign right_occ = occ_w[i+1];
        end

        swtm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LEN_BITS    (LEN_BITS),
            .SUM_BITS    (SUM_BITS),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_sample (sample_reg),
            .old_sample (old_reg),
            .lo         (lo),
            .hi         (hi),
            .left_c_val (left_c_val),
            .left_link  (left_link),
            .right_val  (right_val),
            .right_occ  (right_occ),
            .psum_in    (psum_in),
            .val        (a_val_w[i]),
            .occ        (occ_w[i]),
            .c_val      (c_val_w[i]),
            .link       (link_w[i]),
            .psum_out   (psum_w[i])
        );
    end

    swtm_divider #(
        .LEN_BITS (LEN_BITS),
        .SUM_BITS (SUM_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_GO),
        .dividend (psum_w[MAX_WINDOW-1]),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_stat)
    );

    a_fill_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_len)
        else $error("fill count beyond window length");

    a_occ_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_w) == 32'(fill_reg))
        else $error("occupied cells differ from fill count");

    a_wp_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        (eff_len != '0) |-> (LEN_BITS'(wp_reg) < eff_len))
        else $error("write pointer outside window");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

endmodule

// ===== design/swtm_cell.sv =====
// ----------------------------------------------------------------------------
// swtm_cell: one slot of the sorted window
// Holds one ranked sample, removes the evicted sample and inserts the new one
// using only its neighbors; a middle-rank sample joins the rippling partial sum.
// ----------------------------------------------------------------------------
module swtm_cell #(
    parameter int SAMPLE_BITS = swtm_pkg::DEF_SAMPLE_BITS,
    parameter int LEN_BITS    = 7,
    parameter int SUM_BITS    = 22,
    parameter int INDEX       = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swtm_pkg::cell_ctrl_t ctrl,
    input  logic [SAMPLE_BITS-1:0] new_sample,
    input  logic [SAMPLE_BITS-1:0] old_sample,
    input  logic [LEN_BITS-1:0]  lo,
    input  logic [LEN_BITS-1:0]  hi,
    input  logic [SAMPLE_BITS-1:0] left_c_val,
    input  swtm_pkg::cell_link_t left_link,
    input  logic [SAMPLE_BITS-1:0] right_val,
    input  logic                 right_occ,
    input  logic [SUM_BITS-1:0]  psum_in,
    output logic [SAMPLE_BITS-1:0] val,
    output logic                 occ,
    output logic [SAMPLE_BITS-1:0] c_val,
    output swtm_pkg::cell_link_t link,
    output logic [SUM_BITS-1:0]  psum_out
);

    logic [SAMPLE_BITS-1:0] val_reg;
    logic                   occ_reg;
    logic [SUM_BITS-1:0]    psum_reg;

    logic                   evict;
    logic                   c_occ;
    logic                   gt;
    logic [SAMPLE_BITS-1:0] val_next;
    logic                   occ_next;
    logic                   mid;

    // array after removal: the evicted slot and everything above it shift down
    assign evict = ctrl.full && occ_reg && (val_reg >= old_sample);
    assign c_val = evict ? right_val : val_reg;
    assign c_occ = ctrl.full ? right_occ : occ_reg;
    // empty slots rank above every sample
    assign gt    = !c_occ || (c_val > new_sample);
    assign link  = '{occ: c_occ, gt: gt};

    always_comb
    begin
        val_next = c_val;
        occ_next = c_occ;
        if (gt)
        begin
            if (left_link.gt)
            begin
                val_next = left_c_val;
                occ_next = left_link.occ;
            end
            else
            begin
                val_next = new_sample;
                occ_next = 1'b1;
            end
        end
    end

    assign mid = occ_reg && (LEN_BITS'(INDEX) >= lo) && (LEN_BITS'(INDEX) < hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctrl.update)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            val_reg <= val_next;
        end
        psum_reg <= psum_in + (mid ? SUM_BITS'(val_reg) : '0);
    end

    assign val      = val_reg;
    assign occ      = occ_reg;
    assign psum_out = psum_reg;

endmodule

// ===== design/swtm_divider.sv =====
// ----------------------------------------------------------------------------
// swtm_divider: restoring divider, one quotient bit per cycle
// Divides the middle sum by the number of middle samples.
// ----------------------------------------------------------------------------
module swtm_divider #(
    parameter int LEN_BITS = 7,
    parameter int SUM_BITS = 22
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_BITS-1:0]   dividend,
    input  logic [LEN_BITS-1:0]   divisor,
    output logic [SUM_BITS-1:0]   quotient,
    output swtm_pkg::div_status_t status
);

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic [LEN_BITS-1:0] rem_reg;
    logic [SUM_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [LEN_BITS:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits shift in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? LEN_BITS'(trial - {1'b0, divisor}) : trial[LEN_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign status   = '{busy: busy_reg, done: done_reg};

endmodule

// ===== sim/tb_sliding_window_trimmed_mean.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_trimmed_mean: self-checking bench for the trimmed mean
// Streams samples under several window and trim settings, predicts each
// result with a local sorted-window model and compares every result beat
// field by field, with random idling on both channels and a long result
// hold-off that backs the block up into its sample input.
// ----------------------------------------------------------------------------

typedef struct {
    logic        valid_res;
    logic [15:0] average;
} mean_result_t;

class trimmed_mean_scoreboard;

    logic [swtm_pkg::WLEN_BITS-1:0] wlen;
    logic [swtm_pkg::TRIM_BITS-1:0] trim;
    logic [15:0]  ring [swtm_pkg::DEF_MAX_WINDOW];
    logic [15:0]  ranked [swtm_pkg::DEF_MAX_WINDOW + 1];
    int unsigned  wr_ptr;
    int unsigned  held;
    mean_result_t expected_means [$];
    int unsigned  errors;
    int unsigned  samples_taken;
    int unsigned  results_seen;
    int unsigned  full_results;

    function new();
        wlen          = swtm_pkg::RESET_WINDOW_LENGTH;
        trim          = swtm_pkg::RESET_TRIM_COUNT;
        wr_ptr        = 0;
        held          = 0;
        errors        = 0;
        samples_taken = 0;
        results_seen  = 0;
        full_results  = 0;
    endfunction

    function int unsigned pending();
        return expected_means.size();
    endfunction

    function void write_reg(input logic [swtm_pkg::CFG_IDX_BITS-1:0] idx,
                            input logic [swtm_pkg::CFG_DATA_BITS-1:0] data);
        if (idx == swtm_pkg::REG_WINDOW_LENGTH)
        begin
            wlen   = data[swtm_pkg::WLEN_BITS-1:0];
            wr_ptr = 0;
            held   = 0;
        end
        else if (idx == swtm_pkg::REG_TRIM_COUNT)
        begin
            trim   = data[swtm_pkg::TRIM_BITS-1:0];
            wr_ptr = 0;
            held   = 0;
        end
    endfunction

    // drop one copy of v from the first n ranked entries
    function void drop_ranked(input int unsigned n, input logic [15:0] v);
        int unsigned i;
        i = 0;
        while (i < n && ranked[i] != v)
            i++;
        if (i >= n)
            i = n - 1;
        for (; i + 1 < n; i++)
            ranked[i] = ranked[i + 1];
    endfunction

    function void insert_ranked(input int unsigned n, input logic [15:0] v);
        int unsigned i;
        i = n;
        while (i > 0 && ranked[i - 1] > v)
        begin
            ranked[i] = ranked[i - 1];
            i--;
        end
        ranked[i] = v;
    endfunction

    function void take_sample(input logic [15:0] s);
        int unsigned     len;
        int unsigned     lo;
        int unsigned     hi;
        longint unsigned total;
        mean_result_t    r;
        len = (32'(wlen) > swtm_pkg::DEF_MAX_WINDOW) ? swtm_pkg::DEF_MAX_WINDOW
                                                     : 32'(wlen);
        r.valid_res = 1'b0;
        r.average   = '0;
        samples_taken++;
        if (len > 0)
        begin
            if (wr_ptr >= len)
                wr_ptr = 0;
            if (held > len)
                held = len;
            // full window: oldest sample leaves before the new one goes in
            if (held == len)
            begin
                drop_ranked(held, ring[wr_ptr]);
                held--;
            end
            ring[wr_ptr] = s;
            insert_ranked(held, s);
            held++;
            wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
            if (held == len && 2 * 32'(trim) < len)
            begin
                lo    = 32'(trim);
                hi    = len - 32'(trim);
                total = 0;
                for (int unsigned i = lo; i < hi; i++)
                    total += ranked[i];
                r.valid_res = 1'b1;
                r.average   = 16'(total / (hi - lo));
            end
        end
        expected_means.push_back(r);
    endfunction

    function void flag(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function void check_result(input logic vr, input logic [15:0] avg);
        mean_result_t want;
        if (expected_means.size() == 0)
        begin
            flag($sformatf("mismatch: result beat with nothing expected (valid_res %b avg %0d)",
                           vr, avg));
            return;
        end
        want = expected_means.pop_front();
        results_seen++;
        if (want.valid_res)
            full_results++;
        if (vr !== want.valid_res)
            flag($sformatf("mismatch on result %0d: valid_res expected %b actual %b",
                           results_seen, want.valid_res, vr));
        if (avg !== want.average)
            flag($sformatf("mismatch on result %0d: average expected %0d actual %0d",
                           results_seen, want.average, avg));
    endfunction

endclass

module tb_sliding_window_trimmed_mean;

    localparam int TOTAL_SAMPLES = 1500;
    localparam int HOLD_CYCLES   = 600;

    // indexes outside the register map
    localparam logic [swtm_pkg::CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [swtm_pkg::CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    swtm_cfg_if    cfg_if ();
    swtm_sample_if samp_if ();
    swtm_result_if res_if ();

    sliding_window_trimmed_mean u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .samples (samp_if),
        .results (res_if)
    );

    trimmed_mean_scoreboard sb = new();

    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 85;
    int unsigned cfg_settings  = 0;
    logic        hold_results  = 1'b0;
    logic [15:0] last_sample   = '0;

    always #10 clk = ~clk;

    // result side: check every accepted beat, then pick the next ready
    always @(posedge clk)
    begin
        if (res_if.valid && res_if.ready)
            sb.check_result(res_if.valid_res, res_if.average);
        if (hold_results)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic [15:0] value);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            samp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samp_if.valid  <= 1'b1;
        samp_if.sample <= value;
        do
            @(posedge clk);
        while (!samp_if.ready);
        sb.take_sample(value);
        last_sample = value;
    endtask

    task automatic wait_drained();
        samp_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic cfg_beat(input logic [swtm_pkg::CFG_IDX_BITS-1:0] idx,
                            input logic [swtm_pkg::CFG_DATA_BITS-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_window(input logic [swtm_pkg::CFG_DATA_BITS-1:0] len_data,
                              input logic [swtm_pkg::CFG_DATA_BITS-1:0] trim_data);
        wait_drained();
        if ($urandom_range(1))
        begin
            cfg_beat(swtm_pkg::REG_WINDOW_LENGTH, len_data);
            cfg_beat(swtm_pkg::REG_TRIM_COUNT, trim_data);
        end
        else
        begin
            cfg_beat(swtm_pkg::REG_TRIM_COUNT, trim_data);
            cfg_beat(swtm_pkg::REG_WINDOW_LENGTH, len_data);
        end
        cfg_if.valid <= 1'b0;
        cfg_settings++;
    endtask

    function automatic logic [15:0] pick_sample();
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            6:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            7:       return 16'($urandom_range(3));
            8:       return 16'h7FFC + 16'($urandom_range(7));
            9:       return last_sample;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void set_idling(input int unsigned sent);
        if (sent < TOTAL_SAMPLES / 3)
        begin
            send_idle_pct = 17;
            recv_idle_pct = 85;
        end
        else if (sent < 2 * TOTAL_SAMPLES / 3)
        begin
            send_idle_pct = 85;
            recv_idle_pct = 17;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    initial
    begin
        #(20 * 3_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [swtm_pkg::CFG_DATA_BITS-1:0] len_data;
        logic [swtm_pkg::CFG_DATA_BITS-1:0] trim_data;
        int unsigned                        eff_len;
        int unsigned                        n;
        bit                                 pressure_done;

        pressure_done  = 1'b0;
        rst_n          <= 1'b0;
        samp_if.valid  <= 1'b0;
        samp_if.sample <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: length 3, trim 1; duplicates and both extremes
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);

        // writes outside the register map leave the window alone
        wait_drained();
        cfg_beat(REG_SPARE_2, 8'h5A);
        cfg_beat(REG_SPARE_3, 8'hA5);
        cfg_if.valid <= 1'b0;
        send_sample(16'h5555);
        send_sample(16'hAAAA);

        // trim too large for the length: never valid
        set_window(8'd3, 8'd2);
        repeat (3) send_sample(pick_sample());

        // zero length: nothing kept
        set_window(8'd0, 8'd0);
        repeat (2) send_sample(pick_sample());

        // no trimming, plain mean of three
        set_window(8'd3, 8'd0);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        send_sample(16'hFFFF);
        send_sample(16'h0001);

        set_window(8'd4, 8'd1);
        repeat (4) send_sample(pick_sample());

        while (sb.samples_taken < TOTAL_SAMPLES)
        begin
            set_idling(sb.samples_taken);
            case ($urandom_range(9))
                0:
                begin
                    len_data  = 8'd64;
                    trim_data = 8'd31;
                end
                1:
                begin
                    // length field above the store size saturates
                    len_data  = 8'hFF;
                    trim_data = 8'($urandom);
                end
                2:
                begin
                    len_data  = 8'd64;
                    trim_data = 8'd0;
                end
                3:
                begin
                    len_data  = 8'd3;
                    trim_data = 8'd1;
                end
                4:
                begin
                    len_data  = 8'($urandom_range(1, 2));
                    trim_data = 8'd0;
                end
                5:
                begin
                    len_data  = 8'($urandom);
                    trim_data = 8'($urandom);
                end
                6:
                begin
                    len_data  = 8'd0;
                    trim_data = 8'($urandom_range(31));
                end
                default:
                begin
                    len_data  = 8'($urandom_range(3, 24));
                    trim_data = 8'($urandom_range((len_data - 1) / 2));
                end
            endcase

            // halfway through: stall results while samples keep coming, so the sample input backs up
            if (!pressure_done && sb.samples_taken >= TOTAL_SAMPLES / 2)
            begin
                pressure_done = 1'b1;
                len_data      = 8'd64;
                trim_data     = 8'd5;
                set_window(len_data, trim_data);
                send_idle_pct = 0;
                fork
                    begin
                        hold_results <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_results <= 1'b0;
                    end
                    repeat (150) send_sample(pick_sample());
                join
                continue;
            end

            set_window(len_data, trim_data);
            eff_len = 32'(len_data[swtm_pkg::WLEN_BITS-1:0]);
            if (eff_len > swtm_pkg::DEF_MAX_WINDOW)
                eff_len = swtm_pkg::DEF_MAX_WINDOW;
            if (eff_len == 0)
                eff_len = 8;
            n = eff_len + $urandom_range(10, 40);
            for (int unsigned i = 0; i < n; i++)
            begin
                send_sample(pick_sample());
                // now and then let everything drain mid-stream
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);

        $display("covered %0d samples over %0d window settings with random idling and a %0d cycle hold-off",
                 sb.samples_taken, cfg_settings, HOLD_CYCLES);
        $display("checked %0d results, %0d of them with a full window, %0d mismatches",
                 sb.results_seen, sb.full_results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
